// ===== src/wcag_contrast_checker_unit_assert.svh =====
// assertion macros for the contrast checker
// no dependencies; taken in by the top level with `include
`ifndef WCAG_CONTRAST_CHECKER_UNIT_ASSERT_SVH
`define WCAG_CONTRAST_CHECKER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("contrast checker: implication violated");

// condition holds at every edge out of reset
`define WCC_ASSERT_HOLD(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("contrast checker: invariant violated");

`endif

// ===== src/wcc_pkg.sv =====
// shared types, constants and the linearisation function of the contrast checker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package wcc_pkg;

   localparam int FIELD_W  = 8;
   localparam int NUM_CH   = 6;
   localparam int LUM_W    = 17;
   localparam int LUM_FRAC = 16;
   localparam int WEIGHT_W = 16;
   localparam int PROD_W   = LUM_W + WEIGHT_W;
   localparam int DEN_W    = 21;

   localparam logic [LUM_W-1:0]    LUM_ONE      = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd13933;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd46871;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd4732;
   // 20 * 1.0 + 1.0 in luminance units, numerator for white
   localparam logic [DEN_W-1:0]    WHITE_NUM    = 21'd1376256;

   typedef enum logic [1:0] {
      LEVEL_AA_NORMAL  = 2'd0,
      LEVEL_AA_LARGE   = 2'd1,
      LEVEL_AAA_NORMAL = 2'd2,
      LEVEL_AAA_LARGE  = 2'd3
   } level_type;

   typedef struct packed {
      logic [LUM_W-1:0] fg_lum;
      logic [LUM_W-1:0] bg_lum;
      logic [DEN_W-1:0] bg_den;
   } lum_side_type;

   typedef struct packed {
      logic [3:0]       pad;
      logic [LUM_W-1:0] bg_luminance;
      logic [LUM_W-1:0] fg_luminance;
      logic             auto_fg_black;
      logic             meets_level;
      logic [15:0]      ratio_q;
   } rsp_word_type;

   // 20 * lum + 1.0, the scaled (lum + 0.05)
   function automatic logic [DEN_W-1:0] lum_den(input logic [LUM_W-1:0] lum);
      return (DEN_W'(lum) << 4) + (DEN_W'(lum) << 2) + DEN_W'(LUM_ONE);
   endfunction

   // elaboration-time helpers for the linearisation table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul31(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 31;
   endfunction

   // srgb code to linear q1.16; gamma part is t^2.4 as t^2 * fifth root of t^2
   function automatic logic [LUM_W-1:0] lin_value(input logic [63:0] code,
                                                  input logic [63:0] cmax);
      logic [63:0] den;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] z5;
      logic [63:0] p;
      den = 64'd1292 * cmax;
      if (code * 64'd100000 <= 64'd4045 * cmax) begin
         return LUM_W'(udiv64(code * 64'd6553600 + (den >> 1), den));
      end
      t = udiv64((64'd1000 * code + 64'd55 * cmax) << 31, 64'd1055 * cmax);
      if (t > (64'd1 << 31)) begin
         t = 64'd1 << 31;
      end
      t2 = mul31(t, t);
      lo = '0;
      hi = 64'd1 << 31;
      for (int i = 0; i < 34; i++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            z5  = mul31(mul31(mul31(mul31(mid, mid), mid), mid), mid);
            if (z5 <= t2) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      p = mul31(t2, lo);
      return LUM_W'((p + 64'd16384) >> 15);
   endfunction

endpackage

// ===== src/wcag_contrast_checker_unit.sv =====
// WCAG 2.1 contrast checker: takes one foreground/background colour pair per clock while
// req_tready is high and returns the contrast ratio in Q5.11 (more generally
// RATIO_FRAC_BITS fraction bits), a pass flag against the programmed level, a
// white-or-black auto foreground and both relative luminances in Q1.16. A new pair is
// taken every cycle unless back-pressure holds the front end; each word passes through
// the four-stage luminance front end, the divider that resolves one quotient bit per
// stage and the output register. Back-pressure stops only the stages that are full, so
// words keep entering while a result waits. The level register is written through csr_*
// at any time, always ready, and should change only while no word is in flight.
// depends on wcc_pkg, wcc_lum, wcc_div, wcc_decide and the assertion macro header
`timescale 1ns / 1ps
`include "wcag_contrast_checker_unit_assert.svh"

module wcag_contrast_checker_unit #(
   parameter int CHANNEL_BITS    = 8,
   parameter int RATIO_FRAC_BITS = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ratio_q[15:0], meets_level, auto_fg_black, fg_luminance[16:0], bg_luminance[16:0], zeros
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   localparam int QuoW = RATIO_FRAC_BITS + 5;
   localparam int DenW = wcc_pkg::DEN_W;
   localparam logic [15:0] RatioOneSat =
      ((1 << RATIO_FRAC_BITS) > 65535) ? 16'hFFFF : 16'(1 << RATIO_FRAC_BITS);

   wcc_pkg::level_type level_ff;
   wcc_pkg::level_type level_in;

   logic [wcc_pkg::NUM_CH-1:0][wcc_pkg::FIELD_W-1:0] req_code;
   logic                  lum_valid;
   logic                  lum_ready;
   wcc_pkg::lum_side_type lum_side;
   logic [1:0][DenW-1:0]  lum_num;
   logic [1:0][DenW-1:0]  lum_den;
   logic                  div_valid;
   logic                  div_ready;
   logic [1:0][QuoW-1:0]  div_quo;
   wcc_pkg::lum_side_type div_side;
   wcc_pkg::rsp_word_type rsp_word;

   assign level_in  = csr_valid ? wcc_pkg::level_type'(csr_data) : level_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= wcc_pkg::LEVEL_AA_NORMAL;
      end else begin
         level_ff <= level_in;
      end
   end

   assign req_code = req_tdata;

   wcc_lum #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_lum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_code   (req_code),
      .out_valid (lum_valid),
      .out_ready (lum_ready),
      .out_side  (lum_side),
      .out_num   (lum_num),
      .out_den   (lum_den)
   );

   wcc_div #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lum_valid),
      .in_ready  (lum_ready),
      .in_num    (lum_num),
      .in_den    (lum_den),
      .in_side   (lum_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   wcc_decide #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_quo    (div_quo),
      .in_side   (div_side),
      .level     (level_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   assign rsp_tdata = rsp_word;

   // an empty output register frees every stage behind it
   `WCC_ASSERT_HOLD(a_ready_when_drained, clock, reset, rsp_tvalid || req_tready)
   // equal luminances give a ratio of exactly one
   `WCC_ASSERT_IMPLY(a_equal_unity, clock, reset, rsp_tvalid && (rsp_word.fg_luminance == rsp_word.bg_luminance), rsp_word.ratio_q == RatioOneSat)
   // white on a black background always passes, so white is chosen
   `WCC_ASSERT_IMPLY(a_black_bg_white, clock, reset, rsp_tvalid && (rsp_word.bg_luminance == '0), !rsp_word.auto_fg_black)
   `WCC_ASSERT_IMPLY(a_lum_range, clock, reset, rsp_tvalid, (rsp_word.fg_luminance <= wcc_pkg::LUM_ONE) && (rsp_word.bg_luminance <= wcc_pkg::LUM_ONE) && (rsp_word.ratio_q >= RatioOneSat))

endmodule

// ===== src/wcc_lum.sv =====
// luminance front end: table lookup, weighting, rounding and ratio operands
// depends on wcc_pkg
`timescale 1ns / 1ps

module wcc_lum #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [wcc_pkg::NUM_CH-1:0][wcc_pkg::FIELD_W-1:0] in_code,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output wcc_pkg::lum_side_type                             out_side,
   output logic [1:0][wcc_pkg::DEN_W-1:0]                    out_num,
   output logic [1:0][wcc_pkg::DEN_W-1:0]                    out_den
);

   localparam int Stages    = 4;
   localparam int CodeCount = 2 ** CHANNEL_BITS;
   localparam logic [63:0] CodeMax = 64'(CodeCount - 1);
   localparam int NumCh   = wcc_pkg::NUM_CH;
   localparam int LumW    = wcc_pkg::LUM_W;
   localparam int LumFrac = wcc_pkg::LUM_FRAC;
   localparam int ProdW   = wcc_pkg::PROD_W;
   localparam int SumW    = ProdW + 1;
   localparam int DenW    = wcc_pkg::DEN_W;
   localparam logic [NumCh-1:0][wcc_pkg::WEIGHT_W-1:0] ChWeight = {
      wcc_pkg::WEIGHT_BLUE, wcc_pkg::WEIGHT_GREEN, wcc_pkg::WEIGHT_RED,
      wcc_pkg::WEIGHT_BLUE, wcc_pkg::WEIGHT_GREEN, wcc_pkg::WEIGHT_RED
   };

   logic [LumW-1:0] lin_rom [CodeCount];

   for (genvar g = 0; g < CodeCount; g++) begin : g_rom
      localparam logic [LumW-1:0] LinVal = wcc_pkg::lin_value(64'(g), CodeMax);
      assign lin_rom[g] = LinVal;
   end

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;
   logic [Stages-1:0] ld;

   logic [LumW-1:0]  lin_ff  [NumCh];
   logic [LumW-1:0]  lin_in  [NumCh];
   logic [ProdW-1:0] prod_ff [NumCh];
   logic [ProdW-1:0] prod_in [NumCh];
   logic [LumW-1:0]  lum_ff  [2];
   logic [LumW-1:0]  lum_in  [2];
   logic [SumW-1:0]  lum_sum [2];

   wcc_pkg::lum_side_type          side_ff;
   wcc_pkg::lum_side_type          side_in;
   logic [1:0][DenW-1:0]           num_ff;
   logic [1:0][DenW-1:0]           num_in;
   logic [1:0][DenW-1:0]           den_ff;
   logic [1:0][DenW-1:0]           den_in;
   logic [LumW-1:0]                lum_hi;
   logic [LumW-1:0]                lum_lo;

   // a stage loads when some stage at or after it is empty, or the output moves
   for (genvar k = 0; k < Stages; k++) begin : g_ld
      assign ld[k] = !(&vld_ff[Stages-1:k]) || out_ready;
   end

   always_comb begin
      vld_in = vld_ff;
      for (int k = 0; k < Stages; k++) begin
         if (ld[k]) begin
            vld_in[k] = {vld_ff[Stages-2:0], in_valid}[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NumCh; i++) begin
         lin_in[i]  = lin_rom[CHANNEL_BITS'(in_code[i])];
         prod_in[i] = ProdW'(lin_ff[i]) * ProdW'(ChWeight[i]);
      end
      for (int j = 0; j < 2; j++) begin
         lum_sum[j] = SumW'(prod_ff[3*j]) + SumW'(prod_ff[3*j+1]) + SumW'(prod_ff[3*j+2])
                    + SumW'(32768);
         lum_in[j]  = lum_sum[j][LumFrac +: LumW];
      end
   end

   always_comb begin
      lum_hi         = (lum_ff[0] > lum_ff[1]) ? lum_ff[0] : lum_ff[1];
      lum_lo         = (lum_ff[0] > lum_ff[1]) ? lum_ff[1] : lum_ff[0];
      side_in.fg_lum = lum_ff[0];
      side_in.bg_lum = lum_ff[1];
      side_in.bg_den = wcc_pkg::lum_den(lum_ff[1]);
      // lane 0: pair ratio, lane 1: white against background
      num_in[0]      = wcc_pkg::lum_den(lum_hi);
      den_in[0]      = wcc_pkg::lum_den(lum_lo);
      num_in[1]      = wcc_pkg::WHITE_NUM;
      den_in[1]      = wcc_pkg::lum_den(lum_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         lin_ff <= lin_in;
      end
      if (ld[1]) begin
         prod_ff <= prod_in;
      end
      if (ld[2]) begin
         lum_ff <= lum_in;
      end
      if (ld[3]) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = vld_ff[Stages-1];
   assign out_side  = side_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

// ===== src/wcc_div.sv =====
// two-lane restoring divider, one quotient bit per register stage
// depends on wcc_pkg
`timescale 1ns / 1ps

module wcc_div #(
   parameter int RATIO_FRAC_BITS = 11
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [1:0][wcc_pkg::DEN_W-1:0]             in_num,
   input  logic [1:0][wcc_pkg::DEN_W-1:0]             in_den,
   input  wcc_pkg::lum_side_type                      in_side,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [1:0][RATIO_FRAC_BITS+4:0]            out_quo,
   output wcc_pkg::lum_side_type                      out_side
);

   localparam int DenW = wcc_pkg::DEN_W;
   localparam int QuoW = RATIO_FRAC_BITS + 5;
   localparam int RemW = DenW + RATIO_FRAC_BITS;
   localparam int CmpW = DenW + QuoW;

   logic [QuoW-1:0] vld_ff;
   logic [QuoW-1:0] vld_in;
   logic [QuoW-1:0] ld;

   logic [1:0][RemW-1:0]  stage_rem  [QuoW];
   logic [1:0][DenW-1:0]  stage_den  [QuoW];
   logic [1:0][QuoW-1:0]  stage_quo  [QuoW];
   wcc_pkg::lum_side_type stage_side [QuoW];

   for (genvar k = 0; k < QuoW; k++) begin : g_ld
      assign ld[k] = !(&vld_ff[QuoW-1:k]) || out_ready;
   end

   always_comb begin
      vld_in = vld_ff;
      for (int k = 0; k < QuoW; k++) begin
         if (ld[k]) begin
            vld_in[k] = {vld_ff[QuoW-2:0], in_valid}[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      localparam int Shift = QuoW - 1 - k;

      logic [1:0][RemW-1:0]  rem_src;
      logic [1:0][DenW-1:0]  den_src;
      logic [1:0][QuoW-1:0]  quo_src;
      wcc_pkg::lum_side_type side_src;
      logic [1:0][CmpW-1:0]  den_shift;
      logic [1:0][RemW-1:0]  rem_in;
      logic [1:0][QuoW-1:0]  quo_in;
      logic [1:0][RemW-1:0]  rem_ff;
      logic [1:0][DenW-1:0]  den_ff;
      logic [1:0][QuoW-1:0]  quo_ff;
      wcc_pkg::lum_side_type side_ff;

      if (k == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               rem_src[l] = RemW'(in_num[l]) << RATIO_FRAC_BITS;
               den_src[l] = in_den[l];
               quo_src[l] = '0;
            end
            side_src = in_side;
         end
      end else begin : g_next
         assign rem_src  = stage_rem[k-1];
         assign den_src  = stage_den[k-1];
         assign quo_src  = stage_quo[k-1];
         assign side_src = stage_side[k-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            den_shift[l] = CmpW'(den_src[l]) << Shift;
            if (CmpW'(rem_src[l]) >= den_shift[l]) begin
               rem_in[l] = RemW'(CmpW'(rem_src[l]) - den_shift[l]);
               quo_in[l] = quo_src[l] | (QuoW'(1) << Shift);
            end else begin
               rem_in[l] = rem_src[l];
               quo_in[l] = quo_src[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ld[k]) begin
            rem_ff  <= rem_in;
            den_ff  <= den_src;
            quo_ff  <= quo_in;
            side_ff <= side_src;
         end
      end

      assign stage_rem[k]  = rem_ff;
      assign stage_den[k]  = den_ff;
      assign stage_quo[k]  = quo_ff;
      assign stage_side[k] = side_ff;
   end

   assign in_ready  = ld[0];
   assign out_valid = vld_ff[QuoW-1];
   assign out_quo   = stage_quo[QuoW-1];
   assign out_side  = stage_side[QuoW-1];

endmodule

// ===== src/wcc_decide.sv =====
// threshold compare, auto foreground choice and output register
// depends on wcc_pkg
`timescale 1ns / 1ps

module wcc_decide #(
   parameter int RATIO_FRAC_BITS = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0][RATIO_FRAC_BITS+4:0] in_quo,
   input  wcc_pkg::lum_side_type           in_side,
   input  wcc_pkg::level_type              level,
   output logic                            out_valid,
   input  logic                            out_ready,
   output wcc_pkg::rsp_word_type           out_word
);

   localparam int QuoW    = RATIO_FRAC_BITS + 5;
   localparam int DenW    = wcc_pkg::DEN_W;
   localparam int LumFrac = wcc_pkg::LUM_FRAC;
   localparam int SatW    = (QuoW > 16) ? QuoW : 17;
   localparam logic [QuoW-1:0] ThrAa      = QuoW'(9 << (RATIO_FRAC_BITS - 1));
   localparam logic [QuoW-1:0] ThrAaLarge = QuoW'(3 << RATIO_FRAC_BITS);
   localparam logic [QuoW-1:0] ThrAaa     = QuoW'(7 << RATIO_FRAC_BITS);

   logic                          vld_ff;
   logic                          vld_in;
   logic                          ld;
   wcc_pkg::rsp_word_type         word_ff;
   wcc_pkg::rsp_word_type         word_in;
   logic [QuoW-1:0]               thr;
   logic [QuoW-1:0]               ratio_pair;
   logic [QuoW-1:0]               ratio_white;
   logic [QuoW-1:0]               ratio_black;
   logic [DenW+RATIO_FRAC_BITS-1:0] black_num;
   logic [SatW-1:0]               ratio_wide;

   always_comb begin
      thr = ThrAa;
      unique case (level) inside
         wcc_pkg::LEVEL_AA_LARGE:   thr = ThrAaLarge;
         wcc_pkg::LEVEL_AAA_NORMAL: thr = ThrAaa;
         wcc_pkg::LEVEL_AA_NORMAL, wcc_pkg::LEVEL_AAA_LARGE: thr = ThrAa;
      endcase
   end

   always_comb begin
      ratio_pair  = in_quo[0];
      ratio_white = in_quo[1];
      // black on background divides by exactly 1.0, so it is a shift
      black_num   = {in_side.bg_den, {RATIO_FRAC_BITS{1'b0}}};
      ratio_black = black_num[DenW+RATIO_FRAC_BITS-1:LumFrac];
      ratio_wide  = SatW'(ratio_pair);

      word_in.pad          = '0;
      word_in.fg_luminance = in_side.fg_lum;
      word_in.bg_luminance = in_side.bg_lum;
      word_in.meets_level  = (ratio_pair >= thr);
      word_in.ratio_q      = (ratio_wide > SatW'(17'hFFFF)) ? 16'hFFFF : ratio_wide[15:0];
      if (ratio_white >= thr) begin
         word_in.auto_fg_black = 1'b0;
      end else if (ratio_black >= thr) begin
         word_in.auto_fg_black = 1'b1;
      end else begin
         word_in.auto_fg_black = !(ratio_white > ratio_black);
      end
   end

   assign ld     = !vld_ff || out_ready;
   assign vld_in = ld ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         word_ff <= word_in;
      end
   end

   assign in_ready  = ld;
   assign out_valid = vld_ff;
   assign out_word  = word_ff;

endmodule
